/* design/cvt_pkg.sv */
// Shared constants, codes and control structs of the compacting value table.
package cvt_pkg;

  localparam int DEF_MAX_ENTRIES = 32;
  localparam int LIMIT_W         = 6;
  localparam int VALUE_W         = 32;
  localparam int INDEX_W         = 5;
  localparam int CMD_W           = 2;
  localparam int STATUS_W        = 2;
  localparam int IN_TDATA_W      = 32;
  localparam int OUT_TDATA_W     = 40;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // Command codes carried in in_tuser.
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

  // Result status codes carried in out_tuser.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Sources of a result loaded into the output register.
  localparam logic [2:0] EMIT_APPEND = 3'd0;
  localparam logic [2:0] EMIT_FULL   = 3'd1;
  localparam logic [2:0] EMIT_EMPTY  = 3'd2;
  localparam logic [2:0] EMIT_MISS   = 3'd3;
  localparam logic [2:0] EMIT_HIT    = 3'd4;
  localparam logic [2:0] EMIT_PEND   = 3'd5;

  typedef struct packed {
    logic             latch;     // take the accepted item, restart the walk
    logic             emit;      // load the output register
    logic [2:0]       emit_sel;
    logic             emit_last;
    logic             app_wr;    // store the operand at the end, grow the count
    logic             idx_inc;
    logic             rd_next;   // read the entry above the walk index
    logic             shift_wr;  // move the read entry down to the walk index
    logic             cnt_dec;
    logic             pend_set;
  } cvt_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             room;
    logic             match;
    logic             at_end;
    logic             sh_end;
    logic             pend_v;
    logic             out_free;
  } cvt_sts_t;

endpackage

/* design/cvt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cvt_ctrl.sv */
// Sequencer of the table: steps the walk, shift and result emission.
module cvt_ctrl import cvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  cvt_sts_t  sts,
  output cvt_ctl_t  ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_SHR   = 3'd5;
  localparam logic [2:0] S_SHW   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.latch = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.cmd == CMD_APPEND) begin
          if (sts.out_free) begin
            ctl.emit      = 1'b1;
            ctl.emit_last = 1'b1;
            ctl.emit_sel  = sts.room ? EMIT_APPEND : EMIT_FULL;
            ctl.app_wr    = sts.room;
            state_nxt     = S_IDLE;
          end
        end else if (sts.empty) begin
          if (sts.out_free) begin
            ctl.emit      = 1'b1;
            ctl.emit_last = 1'b1;
            ctl.emit_sel  = EMIT_EMPTY;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (sts.cmd)
          CMD_DUMP: begin
            if (sts.out_free) begin
              ctl.emit      = 1'b1;
              ctl.emit_sel  = EMIT_HIT;
              ctl.emit_last = sts.at_end;
              ctl.idx_inc   = !sts.at_end;
              state_nxt     = sts.at_end ? S_IDLE : S_READ;
            end
          end
          CMD_REMOVE: begin
            if (sts.match) begin
              if (sts.out_free) begin
                ctl.emit      = 1'b1;
                ctl.emit_sel  = EMIT_HIT;
                ctl.emit_last = 1'b1;
                ctl.cnt_dec   = sts.at_end;
                state_nxt     = sts.at_end ? S_IDLE : S_SHR;
              end
            end else if (sts.at_end) begin
              if (sts.out_free) begin
                ctl.emit      = 1'b1;
                ctl.emit_sel  = EMIT_MISS;
                ctl.emit_last = 1'b1;
                state_nxt     = S_IDLE;
              end
            end else begin
              ctl.idx_inc = 1'b1;
              state_nxt   = S_READ;
            end
          end
          default: begin
            // Search holds the latest match back until it is known whether
            // another one follows, which decides its last flag.
            if (sts.match && sts.pend_v) begin
              if (sts.out_free) begin
                ctl.emit     = 1'b1;
                ctl.emit_sel = EMIT_PEND;
                ctl.pend_set = 1'b1;
                ctl.idx_inc  = !sts.at_end;
                state_nxt    = sts.at_end ? S_FLUSH : S_READ;
              end
            end else begin
              ctl.pend_set = sts.match;
              ctl.idx_inc  = !sts.at_end;
              state_nxt    = sts.at_end ? S_FLUSH : S_READ;
            end
          end
        endcase
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_last = 1'b1;
          ctl.emit_sel  = sts.pend_v ? EMIT_PEND : EMIT_MISS;
          state_nxt     = S_IDLE;
        end
      end
      S_SHR: begin
        ctl.rd_next = 1'b1;
        state_nxt   = S_SHW;
      end
      S_SHW: begin
        ctl.shift_wr = 1'b1;
        ctl.idx_inc  = 1'b1;
        ctl.cnt_dec  = sts.sh_end;
        state_nxt    = sts.sh_end ? S_IDLE : S_SHR;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A shift step always moves an entry that lies inside the table.
  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_wr |-> !sts.empty && !sts.at_end)
    else $error("shift step past the end of the table");

  // The walk only starts for a non-append command on a non-empty table.
  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START && state_nxt == S_READ) |-> sts.cmd != CMD_APPEND && !sts.empty)
    else $error("walk started for append or on an empty table");

  a_state_known: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= S_SHW)
    else $error("sequencer in an unknown state");

endmodule

/* design/cvt_dp.sv */
// Datapath of the table: entry RAM, fill count, walk index and output register.
module cvt_dp import cvt_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_W-1:0]     cfg_wr_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]    out_tuser,
  output logic                   out_tlast,
  input  cvt_ctl_t               ctl,
  output cvt_sts_t               sts
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CAP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0]     limit_r;
  logic [CNT_W-1:0]       count_r;
  logic [CMD_W-1:0]       cmd_r;
  logic [VALUE_W-1:0]     val_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   pend_v_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic [VALUE_W-1:0]     pend_val_r;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [INDEX_W-1:0]     out_index_r;
  logic [VALUE_W-1:0]     out_value_r;
  logic                   out_last_r;

  logic [CAP_W-1:0]       lim_x, max_x, cap_x;
  logic [CNT_W-1:0]       cap;
  logic [CNT_W:0]         idx_x, cnt_x;
  logic [VALUE_W-1:0]     rdata;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]     ram_wdata;
  logic                   out_free;
  logic [STATUS_W-1:0]    sel_status;
  logic [IDX_W-1:0]       sel_idx;
  logic [VALUE_W-1:0]     sel_value;
  logic [IDX_W+INDEX_W-1:0] sel_idx_wide;

  // Capacity: a limit of zero acts as one, anything above the depth as the depth.
  assign lim_x = CAP_W'(limit_r);
  assign max_x = CAP_W'(MAX_ENTRIES);
  assign cap_x = (lim_x == '0) ? CAP_W'(1) : ((lim_x > max_x) ? max_x : lim_x);
  assign cap   = cap_x[CNT_W-1:0];

  assign idx_x = (CNT_W+1)'(idx_r);
  assign cnt_x = (CNT_W+1)'(count_r);

  assign out_free = !out_valid_r || out_tready;

  assign sts.cmd      = cmd_r;
  assign sts.empty    = (count_r == '0);
  assign sts.room     = (count_r < cap);
  assign sts.match    = (rdata == val_r);
  assign sts.at_end   = (idx_x + (CNT_W+1)'(1) == cnt_x);
  assign sts.sh_end   = (idx_x + (CNT_W+1)'(2) >= cnt_x);
  assign sts.pend_v   = pend_v_r;
  assign sts.out_free = out_free;

  assign ram_we    = ctl.app_wr || ctl.shift_wr;
  assign ram_waddr = ctl.app_wr ? count_r[IDX_W-1:0] : idx_r;
  assign ram_wdata = ctl.app_wr ? val_r : rdata;
  assign ram_raddr = ctl.rd_next ? idx_r + IDX_W'(1) : idx_r;

  cvt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    sel_status = ST_OK;
    sel_idx    = '0;
    sel_value  = '0;
    case (ctl.emit_sel)
      EMIT_APPEND: begin
        sel_idx   = count_r[IDX_W-1:0];
        sel_value = val_r;
      end
      EMIT_FULL:  sel_status = ST_FULL;
      EMIT_EMPTY: sel_status = ST_EMPTY;
      EMIT_MISS:  sel_status = ST_MISS;
      EMIT_HIT: begin
        sel_idx   = idx_r;
        sel_value = rdata;
      end
      EMIT_PEND: begin
        sel_idx   = pend_idx_r;
        sel_value = pend_val_r;
      end
      default: sel_status = ST_OK;
    endcase
  end

  assign sel_idx_wide = (IDX_W+INDEX_W)'(sel_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
        count_r <= '0;
      end else if (ctl.app_wr) begin
        count_r <= count_r + CNT_W'(1);
      end else if (ctl.cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (ctl.latch) begin
        pend_v_r <= 1'b0;
      end else if (ctl.pend_set) begin
        pend_v_r <= 1'b1;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= in_tuser;
      val_r <= in_tdata;
      idx_r <= '0;
    end else if (ctl.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (ctl.pend_set) begin
      pend_idx_r <= idx_r;
      pend_val_r <= rdata;
    end
    if (ctl.emit) begin
      out_status_r <= sel_status;
      out_index_r  <= sel_idx_wide[INDEX_W-1:0];
      out_value_r  <= sel_value;
      out_last_r   <= ctl.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W-VALUE_W-INDEX_W)'(0), out_value_r, out_index_r};

  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap)
    else $error("fill count above capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> out_free)
    else $error("result loaded over an untaken result");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.app_wr |-> (count_r < cap) && !cfg_wr_en)
    else $error("append stored into a full table");

endmodule

/* design/compacting_value_table_unit.sv */
// Top level of the compacting value table: sequencer plus datapath.
//
//   channel | ports                          | contents
//   --------+--------------------------------+--------------------------------------
//   in      | in_tvalid/in_tready            | tdata: operand_value; tuser: cmd
//   out     | out_tvalid/out_tready/out_tlast| tdata: entry_index, entry_value; tuser: status
//   cfg     | cfg_wr_en/cfg_wr_data          | table_limit, write empties the table
//
// The entry RAM read is registered, so dump walks the entries with a read state and a
// check state each, search adds a flush state, and remove compares entries until a
// match, then moves each later entry down with a read and a write state.
// Reset sets the fill count to zero and the limit to 32; the RAM is not cleared.
// A new item is taken only after the previous one is done; a stalled output
// holds the walk until the output register frees up.
module compacting_value_table_unit import cvt_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_W-1:0]     cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] operand_value
  input  logic [CMD_W-1:0]       in_tuser,   // [1:0] cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [4:0] entry_index, [36:5] entry_value
  output logic [STATUS_W-1:0]    out_tuser,  // [1:0] status
  output logic                   out_tlast   // last
);

  cvt_ctl_t ctl;
  cvt_sts_t sts;

  cvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  cvt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .ctl         (ctl),
    .sts         (sts)
  );

endmodule
